// File: rtl/core/cese_pkg.sv
package cese_pkg;

   localparam int CACHE_FRAMES_DEFAULT = 16;

   // event kinds
   localparam logic [2:0] EV_START = 3'd0;
   localparam logic [2:0] EV_FETCH = 3'd1;
   localparam logic [2:0] EV_STOP  = 3'd2;
   localparam logic [2:0] EV_CTRL  = 3'd3;
   localparam logic [2:0] EV_TICK  = 3'd4;

   // capture phase
   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_EXPOSING = 2'd1;
   localparam logic [1:0] PH_READING  = 2'd2;

   // run mode
   localparam logic [1:0] RM_SINGLE = 2'd0;
   localparam logic [1:0] RM_LIVE   = 2'd1;
   localparam logic [1:0] RM_BURST  = 2'd2;

   // start / fetch answer
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  frame_count;
      logic [31:0] shutter_us;
      logic [7:0]  cached_frames;
      logic        memory_ready;
      logic        frame_stored;
      logic        send_done;
      logic        frame_fault;
   } cese_req_type;

   typedef struct packed {
      logic [1:0] capture_state;
      logic [1:0] capture_mode;
      logic [1:0] status;
      logic       begin_exposure;
      logic       end_exposure;
      logic       send_trigger;
      logic       sending;
      logic       paused_full;
      logic       state_changed;
   } cese_rsp_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [1:0]  run_mode;
      logic [31:0] exposure_length;
      logic [31:0] exposure_left;
      logic        timer_running;
      logic [7:0]  burst_left;
      logic [7:0]  fetch_left;
      logic        send_busy;
      logic        full_wait;
   } cese_state_type;

endpackage

// File: rtl/core/cese_if.sv
interface cese_req_if;
   logic                      valid;
   logic                      ready;
   cese_pkg::cese_req_type    payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cese_rsp_if;
   logic                      valid;
   logic                      ready;
   cese_pkg::cese_rsp_type    payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/cese_step.sv
module cese_step #(
   parameter int CACHE_FRAMES = cese_pkg::CACHE_FRAMES_DEFAULT
) (
   input  cese_pkg::cese_state_type cur,
   input  cese_pkg::cese_req_type   ev,
   output cese_pkg::cese_state_type nxt,
   output cese_pkg::cese_rsp_type   rsp
);

   localparam logic [8:0] CacheLimit = 9'(CACHE_FRAMES);

   logic       cache_full;
   logic       start_overflow;

   assign cache_full     = {1'b0, ev.cached_frames} >= CacheLimit;
   assign start_overflow = ({1'b0, ev.cached_frames} + {1'b0, ev.frame_count}) > CacheLimit;

   always_comb begin
      cese_pkg::cese_state_type s;
      logic [1:0] status;
      logic       p_begin;
      logic       p_end;
      logic       p_trig;
      logic       p_chg;
      logic       fw_done;
      logic       sd_done;

      s       = cur;
      status  = cese_pkg::ST_OK;
      p_begin = 1'b0;
      p_end   = 1'b0;
      p_trig  = 1'b0;
      p_chg   = 1'b0;
      fw_done = 1'b0;
      sd_done = 1'b0;

      case (ev.mode)
         cese_pkg::EV_START: begin
            if (s.phase != cese_pkg::PH_IDLE) begin
               status = cese_pkg::ST_BUSY;
            end else if (ev.frame_count != 8'd0 && start_overflow) begin
               status = cese_pkg::ST_FAIL;
            end else begin
               s.run_mode = (ev.frame_count == 8'd0) ? cese_pkg::RM_LIVE :
                            (ev.frame_count == 8'd1) ? cese_pkg::RM_SINGLE :
                                                       cese_pkg::RM_BURST;
               s.exposure_length = ev.shutter_us;
               s.burst_left      = ev.frame_count;
               s.full_wait       = 1'b0;
               if (ev.memory_ready) begin
                  s.exposure_left = s.exposure_length;
                  s.timer_running = 1'b1;
                  s.phase         = cese_pkg::PH_EXPOSING;
                  p_begin         = 1'b1;
                  p_chg           = 1'b1;
               end else begin
                  status       = cese_pkg::ST_BUSY;
                  s.run_mode   = cese_pkg::RM_SINGLE;
                  s.burst_left = 8'd0;
               end
            end
         end
         cese_pkg::EV_FETCH: begin
            if (s.fetch_left != 8'd0) begin
               status = cese_pkg::ST_BUSY;
            end else if (ev.frame_count == 8'd0 || ev.cached_frames < ev.frame_count) begin
               status = cese_pkg::ST_FAIL;
            end else begin
               s.fetch_left = ev.frame_count;
               s.send_busy  = 1'b1;
               p_trig       = 1'b1;
            end
         end
         cese_pkg::EV_STOP: begin
            p_end           = 1'b1;
            s.timer_running = 1'b0;
            s.fetch_left    = 8'd0;
            s.burst_left    = 8'd0;
            s.send_busy     = 1'b0;
            s.full_wait     = 1'b0;
            s.phase         = cese_pkg::PH_IDLE;
            p_chg           = 1'b1;
         end
         cese_pkg::EV_CTRL: begin
            // frame written
            if (ev.frame_stored) begin
               if (s.run_mode == cese_pkg::RM_SINGLE) begin
                  s.phase = cese_pkg::PH_IDLE;
                  p_chg   = 1'b1;
                  fw_done = 1'b1;
               end else if (s.burst_left != 8'd0) begin
                  s.burst_left = s.burst_left - 8'd1;
                  if (s.burst_left == 8'd0) begin
                     s.full_wait = 1'b0;
                     s.phase     = cese_pkg::PH_IDLE;
                     p_chg       = 1'b1;
                     fw_done     = 1'b1;
                  end
               end
               if (!fw_done) begin
                  if (cache_full) begin
                     s.full_wait = 1'b1;
                  end else begin
                     s.full_wait = 1'b0;
                     if (ev.memory_ready) begin
                        s.exposure_left = s.exposure_length;
                        s.timer_running = 1'b1;
                        s.phase         = cese_pkg::PH_EXPOSING;
                        p_begin         = 1'b1;
                        p_chg           = 1'b1;
                     end
                  end
               end
            end
            // send done
            if (ev.send_done) begin
               if (s.fetch_left != 8'd0) begin
                  s.fetch_left = s.fetch_left - 8'd1;
                  if (s.fetch_left != 8'd0) begin
                     p_trig  = 1'b1;
                     sd_done = 1'b1;
                  end
               end
               if (!sd_done) begin
                  if (s.full_wait && !cache_full) begin
                     s.full_wait = 1'b0;
                     if (ev.memory_ready) begin
                        s.exposure_left = s.exposure_length;
                        s.timer_running = 1'b1;
                        s.phase         = cese_pkg::PH_EXPOSING;
                        p_begin         = 1'b1;
                        p_chg           = 1'b1;
                     end
                  end
                  s.send_busy = 1'b0;
               end
            end
            // frame fault aborts everything
            if (ev.frame_fault) begin
               p_end           = 1'b1;
               s.timer_running = 1'b0;
               s.fetch_left    = 8'd0;
               s.burst_left    = 8'd0;
               s.send_busy     = 1'b0;
               s.full_wait     = 1'b0;
               s.phase         = cese_pkg::PH_IDLE;
               p_chg           = 1'b1;
            end
         end
         cese_pkg::EV_TICK: begin
            if (s.timer_running) begin
               if (s.exposure_left <= 32'd1) begin
                  s.exposure_left = 32'd0;
                  s.timer_running = 1'b0;
                  p_end           = 1'b1;
                  s.phase         = cese_pkg::PH_READING;
                  p_chg           = 1'b1;
               end else begin
                  s.exposure_left = s.exposure_left - 32'd1;
               end
            end
         end
         default: begin
         end
      endcase

      nxt                = s;
      rsp.capture_state  = s.phase;
      rsp.capture_mode   = s.run_mode;
      rsp.status         = status;
      rsp.begin_exposure = p_begin;
      rsp.end_exposure   = p_end;
      rsp.send_trigger   = p_trig;
      rsp.sending        = s.send_busy;
      rsp.paused_full    = s.full_wait;
      rsp.state_changed  = p_chg;
   end

endmodule

// File: rtl/core/capture_exposure_sequencer_unit.sv
// A beat accepted on req_chan passes through the input register, then the
// result register, before it shows on rsp_chan.
// Throughput: one event per cycle while rsp_chan takes beats every cycle.
// Reset (synchronous, active high): phase idle, mode single, all counters,
// timer and flags cleared, both pipeline registers empty.
module capture_exposure_sequencer_unit #(
   parameter int CACHE_FRAMES = cese_pkg::CACHE_FRAMES_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   cese_req_if.sink    req_chan,
   cese_rsp_if.source  rsp_chan
);

   // input register
   logic                     in_valid_ff;
   logic                     in_valid_in;
   cese_pkg::cese_req_type   in_data_ff;

   // sequencer state, updated once per event as it leaves the input register
   cese_pkg::cese_state_type state_ff;
   cese_pkg::cese_state_type state_in;

   // result register
   logic                     out_valid_ff;
   logic                     out_valid_in;
   cese_pkg::cese_rsp_type   out_data_ff;
   cese_pkg::cese_rsp_type   out_data_in;

   logic                     advance;
   logic                     req_take;

   // An event moves on when the result register is empty or drains this cycle;
   // the input register refills in the same cycle, so back-to-back beats flow.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   cese_step #(
      .CACHE_FRAMES (CACHE_FRAMES)
   ) u_step (
      .cur (state_ff),
      .ev  (in_data_ff),
      .nxt (state_in),
      .rsp (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase:           cese_pkg::PH_IDLE,
                           run_mode:        cese_pkg::RM_SINGLE,
                           exposure_length: 32'd0,
                           exposure_left:   32'd0,
                           timer_running:   1'b0,
                           burst_left:      8'd0,
                           fetch_left:      8'd0,
                           send_busy:       1'b0,
                           full_wait:       1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule
